/* rtl/nvs_pkg.sv */
package nvs_pkg;

	localparam int MAX_NODES  = 1024;
	localparam int COORD_BITS = 16;
	localparam int IDX_W      = $clog2(MAX_NODES);
	localparam int CNT_W      = IDX_W + 1;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int SQ_W       = 2 * COORD_BITS + 1;
	localparam int DIST_W     = 2 * COORD_BITS + 2;

	localparam logic [1:0] OP_LOAD     = 2'd0;
	localparam logic [1:0] OP_NEAREST  = 2'd1;
	localparam logic [1:0] OP_NEIGHBOR = 2'd2;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [IDX_W-1:0] node_index;
		coord_t           pos_x;
		coord_t           pos_y;
		coord_t           pos_z;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  result_index;
		logic [DIST_W-1:0] distance_sq;
		logic              status;
	} rsp_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vertex_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic             first;
		logic             tie_prev;
		logic             use_y;
		logic [IDX_W-1:0] idx;
	} tag_t;

endpackage

/* rtl/nvs_vertex_mem.sv */
module nvs_vertex_mem (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [nvs_pkg::IDX_W-1:0]   wr_addr,
	input  nvs_pkg::vertex_t            wr_data,
	input  logic                        rd_en,
	input  logic [nvs_pkg::IDX_W-1:0]   rd_addr,
	output nvs_pkg::vertex_t            rd_data
);

	nvs_pkg::vertex_t mem_q [nvs_pkg::MAX_NODES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/nvs_dist_pipe.sv */
module nvs_dist_pipe (
	input  logic                        clk,
	input  logic                        arst_n,
	input  nvs_pkg::tag_t               tag,
	input  nvs_pkg::vertex_t            vtx,
	input  nvs_pkg::vertex_t            qry,
	output nvs_pkg::tag_t               tag_out,
	output logic [nvs_pkg::DIST_W-1:0]  dist_sq
);

	nvs_pkg::tag_t tag_s1, tag_s2, tag_s3, tag_s4;

	logic signed [nvs_pkg::DIFF_W-1:0]   dx_s2, dy_s2, dz_s2;
	logic signed [2*nvs_pkg::DIFF_W-1:0] px, py, pz;
	logic [nvs_pkg::SQ_W-1:0]            sqx_s3, sqy_s3, sqz_s3;
	logic [nvs_pkg::DIST_W-1:0]          dist_s4;

	// The read data of the vertex memory lines up with tag_s1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2 <= {vtx.x[nvs_pkg::COORD_BITS-1], vtx.x} - {qry.x[nvs_pkg::COORD_BITS-1], qry.x};
		dz_s2 <= {vtx.z[nvs_pkg::COORD_BITS-1], vtx.z} - {qry.z[nvs_pkg::COORD_BITS-1], qry.z};
		if (tag_s1.use_y) begin
			dy_s2 <= {vtx.y[nvs_pkg::COORD_BITS-1], vtx.y}
				- {qry.y[nvs_pkg::COORD_BITS-1], qry.y};
		end else begin
			dy_s2 <= '0;
		end
	end

	assign px = dx_s2 * dx_s2;
	assign py = dy_s2 * dy_s2;
	assign pz = dz_s2 * dz_s2;

	always_ff @(posedge clk) begin
		sqx_s3  <= px[nvs_pkg::SQ_W-1:0];
		sqy_s3  <= py[nvs_pkg::SQ_W-1:0];
		sqz_s3  <= pz[nvs_pkg::SQ_W-1:0];
		dist_s4 <= {1'b0, sqx_s3} + {1'b0, sqy_s3} + {1'b0, sqz_s3};
	end

	assign tag_out = tag_s4;
	assign dist_sq = dist_s4;

endmodule

/* rtl/nearest_vertex_search_unit.sv */
// Nearest vertex search over a table of 3D ring vertices.
// Requests arrive on req with req_valid; the block holds req_stall high while it works.
// Results leave on rsp with rsp_valid and wait in an output register while rsp_stall is high.
// The vertex count register is written through cfg_valid and cfg_ready while the block is idle.
// A load transaction writes one vertex into the table memory and gives no result. A nearest
// query streams entries 0 to n-1 out of the memory, one read per cycle, through a four-stage
// distance pipeline, and the single memory read port sets its throughput at one entry per cycle.
// A neighbor query reads two entries; an index not below the effective vertex count (a count
// of 0 acts as 1) answers with the error status.
// A new request is accepted as soon as the previous one has placed its result in the output
// register, even while that result is still stalled; a finished query waits for the output
// register to free up before the next request is taken.
// Reset clears the control state and sets the vertex count to 1; the vertex table is not
// cleared, and every entry must be loaded before a query reads it.
module nearest_vertex_search_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  nvs_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output nvs_pkg::rsp_t               rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [nvs_pkg::CNT_W-1:0]   cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_SCAN     = 6'b000010,
		ST_NBR_NEXT = 6'b000100,
		ST_NBR_PREV = 6'b001000,
		ST_WAIT     = 6'b010000,
		ST_FINISH   = 6'b100000
	} state_t;

	state_t                       state_q;
	logic [nvs_pkg::IDX_W-1:0]    addr_q, nx_q, pv_q;
	logic [nvs_pkg::CNT_W-1:0]    vcount_q, n_eff, n_m1, node_ext, node_inc;
	nvs_pkg::vertex_t             qry_q, rd_data;
	logic                         err_q;
	logic [nvs_pkg::IDX_W-1:0]    best_idx_q;
	logic [nvs_pkg::DIST_W-1:0]   best_dist_q, cand_dist;
	nvs_pkg::rsp_t                rsp_q;
	logic                         rsp_valid_q;
	nvs_pkg::tag_t                issue, tag_out;
	logic                         req_fire, load_en, rsp_free, take_best;

	assign req_stall = (state_q != ST_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign cfg_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign load_en   = req_fire && (req.opcode == nvs_pkg::OP_LOAD);

	always_comb begin
		if (vcount_q == '0) begin
			n_eff = nvs_pkg::CNT_W'(1);
		end else if (vcount_q > nvs_pkg::CNT_W'(nvs_pkg::MAX_NODES)) begin
			n_eff = nvs_pkg::CNT_W'(nvs_pkg::MAX_NODES);
		end else begin
			n_eff = vcount_q;
		end
	end

	assign n_m1     = n_eff - 1'b1;
	assign node_ext = {1'b0, req.node_index};
	assign node_inc = node_ext + 1'b1;

	always_comb begin
		issue = '0;
		unique case (state_q)
			ST_SCAN: begin
				issue.valid = 1'b1;
				issue.idx   = addr_q;
				issue.last  = ({1'b0, addr_q} == n_m1);
				issue.first = (addr_q == '0);
				issue.use_y = 1'b1;
			end
			ST_NBR_NEXT: begin
				issue.valid = 1'b1;
				issue.idx   = nx_q;
				issue.first = 1'b1;
			end
			ST_NBR_PREV: begin
				issue.valid    = 1'b1;
				issue.idx      = pv_q;
				issue.last     = 1'b1;
				issue.tie_prev = 1'b1;
			end
			default: begin
				issue = '0;
			end
		endcase
	end

	nvs_vertex_mem u_mem (
		.clk     (clk),
		.wr_en   (load_en),
		.wr_addr (req.node_index),
		.wr_data ({req.pos_x, req.pos_y, req.pos_z}),
		.rd_en   (issue.valid),
		.rd_addr (issue.idx),
		.rd_data (rd_data)
	);

	nvs_dist_pipe u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag     (issue),
		.vtx     (rd_data),
		.qry     (qry_q),
		.tag_out (tag_out),
		.dist_sq (cand_dist)
	);

	assign take_best = tag_out.valid && (tag_out.first || (cand_dist < best_dist_q)
		|| (tag_out.tie_prev && (cand_dist == best_dist_q)));

	always_ff @(posedge clk) begin
		if (take_best) begin
			best_idx_q  <= tag_out.idx;
			best_dist_q <= cand_dist;
		end
		if (req_fire) begin
			qry_q <= {req.pos_x, req.pos_y, req.pos_z};
			err_q <= (req.opcode == nvs_pkg::OP_NEIGHBOR) && (node_ext >= n_eff);
			nx_q  <= (node_inc == n_eff) ? '0 : node_inc[nvs_pkg::IDX_W-1:0];
			pv_q  <= (req.node_index == '0) ? n_m1[nvs_pkg::IDX_W-1:0]
				: req.node_index - 1'b1;
		end
		if (state_q == ST_FINISH && rsp_free) begin
			if (err_q) begin
				rsp_q <= '{result_index: '0, distance_sq: '0, status: 1'b1};
			end else begin
				rsp_q <= '{result_index: best_idx_q, distance_sq: best_dist_q, status: 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			addr_q      <= '0;
			vcount_q    <= nvs_pkg::CNT_W'(1);
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				vcount_q <= cfg_data;
			end
			if (state_q == ST_FINISH && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						addr_q <= '0;
						if (req.opcode == nvs_pkg::OP_NEAREST) begin
							state_q <= ST_SCAN;
						end else if (req.opcode == nvs_pkg::OP_NEIGHBOR) begin
							state_q <= (node_ext >= n_eff) ? ST_FINISH : ST_NBR_NEXT;
						end
					end
				end
				ST_SCAN: begin
					if (issue.last) begin
						state_q <= ST_WAIT;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_NBR_NEXT: begin
					state_q <= ST_NBR_PREV;
				end
				ST_NBR_PREV: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (tag_out.valid && tag_out.last) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* bench/nearest_vertex_search_unit_tb.sv */
module nearest_vertex_search_unit_tb;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int LIMIT_CYCLES = 10000000;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_CYCLES = nvs_pkg::MAX_NODES + 64;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      req_valid = 1'b0;
	logic                      req_stall;
	nvs_pkg::req_t             req       = '0;
	logic                      rsp_valid;
	logic                      rsp_stall = 1'b1;
	nvs_pkg::rsp_t             rsp;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [nvs_pkg::CNT_W-1:0] cfg_data  = '0;

	nearest_vertex_search_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	nvs_pkg::vertex_t          vertex_mem [nvs_pkg::MAX_NODES];
	bit                        vertex_loaded [nvs_pkg::MAX_NODES];
	logic [nvs_pkg::CNT_W-1:0] vcount_shadow = nvs_pkg::CNT_W'(1);
	nvs_pkg::rsp_t             owed_answers [$];

	int     mismatch_count  = 0;
	int     answers_checked = 0;
	int     loads_done      = 0;
	int     range_errors    = 0;
	int     count_writes    = 0;
	longint cycle_count     = 0;
	bit     no_gaps         = 1'b0;
	bit     hold_request    = 1'b0;
	int     hold_left       = 0;
	int     seg_left        = 0;
	bit     seg_stall       = 1'b0;

	always #2 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic int active_nodes();
		if (vcount_shadow == 0)
			return 1;
		if (int'(vcount_shadow) > nvs_pkg::MAX_NODES)
			return nvs_pkg::MAX_NODES;
		return int'(vcount_shadow);
	endfunction

	function automatic longint unsigned sq_diff(input nvs_pkg::coord_t a,
			input nvs_pkg::coord_t b);
		longint d;
		d = longint'(a) - longint'(b);
		return d * d;
	endfunction

	function automatic nvs_pkg::req_t make_item(input logic [1:0] op, input int node,
			input int x, input int y, input int z);
		nvs_pkg::req_t it;
		it.opcode     = op;
		it.node_index = nvs_pkg::IDX_W'(node);
		it.pos_x      = nvs_pkg::coord_t'(x);
		it.pos_y      = nvs_pkg::coord_t'(y);
		it.pos_z      = nvs_pkg::coord_t'(z);
		return it;
	endfunction

	function automatic nvs_pkg::coord_t random_coord(input bit clustered);
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return nvs_pkg::coord_t'(16'h8000);
		if (r < 20)
			return nvs_pkg::coord_t'(16'h7fff);
		if (clustered || r < 45)
			return nvs_pkg::coord_t'(int'($urandom_range(0, 8)) - 4);
		return nvs_pkg::coord_t'($urandom());
	endfunction

	function automatic nvs_pkg::req_t random_item(input int n, input bit clustered);
		nvs_pkg::req_t it;
		int r;
		r = $urandom_range(0, 99);
		it.pos_x = random_coord(clustered);
		it.pos_y = random_coord(clustered);
		it.pos_z = random_coord(clustered);
		it.node_index = nvs_pkg::IDX_W'($urandom_range(0, nvs_pkg::MAX_NODES - 1));
		if (r < 30) begin
			it.opcode = nvs_pkg::OP_LOAD;
			if ($urandom_range(0, 9) < 7)
				it.node_index = nvs_pkg::IDX_W'($urandom_range(0, n - 1));
		end else if (r < 60) begin
			it.opcode = nvs_pkg::OP_NEAREST;
		end else if (r < 95) begin
			it.opcode = nvs_pkg::OP_NEIGHBOR;
			if (n < nvs_pkg::MAX_NODES && $urandom_range(0, 9) == 0)
				it.node_index = nvs_pkg::IDX_W'($urandom_range(n, nvs_pkg::MAX_NODES - 1));
			else
				it.node_index = nvs_pkg::IDX_W'($urandom_range(0, n - 1));
		end else begin
			it.opcode = OP_UNUSED;
		end
		return it;
	endfunction

	task automatic predict_answer(input nvs_pkg::req_t item);
		nvs_pkg::rsp_t ans;
		int n, nxt, prv, best_i;
		longint unsigned d, best_d, d_next, d_prev;
		n = active_nodes();
		ans = '0;
		case (item.opcode)
			nvs_pkg::OP_LOAD: begin
				vertex_mem[item.node_index].x = item.pos_x;
				vertex_mem[item.node_index].y = item.pos_y;
				vertex_mem[item.node_index].z = item.pos_z;
				vertex_loaded[item.node_index] = 1'b1;
				loads_done++;
			end
			nvs_pkg::OP_NEAREST: begin
				best_i = 0;
				best_d = 0;
				for (int i = 0; i < n; i++) begin
					d = sq_diff(vertex_mem[i].x, item.pos_x) + sq_diff(vertex_mem[i].y, item.pos_y)
						+ sq_diff(vertex_mem[i].z, item.pos_z);
					if (i == 0 || d < best_d) begin
						best_d = d;
						best_i = i;
					end
				end
				ans.result_index = nvs_pkg::IDX_W'(best_i);
				ans.distance_sq = nvs_pkg::DIST_W'(best_d);
				owed_answers.push_back(ans);
			end
			nvs_pkg::OP_NEIGHBOR: begin
				if (int'(item.node_index) >= n) begin
					ans.status = 1'b1;
					range_errors++;
				end else begin
					nxt = (int'(item.node_index) + 1) % n;
					prv = (int'(item.node_index) + n - 1) % n;
					d_next = sq_diff(item.pos_x, vertex_mem[nxt].x)
						+ sq_diff(item.pos_z, vertex_mem[nxt].z);
					d_prev = sq_diff(item.pos_x, vertex_mem[prv].x)
						+ sq_diff(item.pos_z, vertex_mem[prv].z);
					if (d_next < d_prev) begin
						ans.result_index = nvs_pkg::IDX_W'(nxt);
						ans.distance_sq = nvs_pkg::DIST_W'(d_next);
					end else begin
						ans.result_index = nvs_pkg::IDX_W'(prv);
						ans.distance_sq = nvs_pkg::DIST_W'(d_prev);
					end
				end
				owed_answers.push_back(ans);
			end
			default: begin
			end
		endcase
	endtask

	// Every task that drives the request side starts and ends at a falling edge.
	task automatic send_item(input nvs_pkg::req_t item);
		int gap;
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predict_answer(item);
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_results_drained();
		req_valid <= 1'b0;
		wait (owed_answers.size() == 0);
		@(negedge clk);
	endtask

	task automatic write_vertex_count(input int value);
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_data <= nvs_pkg::CNT_W'(value);
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		vcount_shadow = nvs_pkg::CNT_W'(value);
		count_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic fill_table(input int n);
		for (int i = 0; i < n; i++) begin
			if (!vertex_loaded[i])
				send_item(make_item(nvs_pkg::OP_LOAD, i, random_coord(1'b0),
					random_coord(1'b0), random_coord(1'b0)));
		end
	endtask

	task automatic random_burst(input int total, input bit clustered);
		nvs_pkg::req_t it;
		int sent;
		sent = 0;
		while (sent < total) begin
			it = random_item(active_nodes(), clustered);
			send_item(it);
			if (it.opcode != OP_UNUSED)
				sent++;
		end
	endtask

	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			if (seg_left == 0) begin
				seg_stall = ~seg_stall;
				seg_left = seg_stall ? pick_gap() : $urandom_range(1, 10);
				if (seg_left == 0) begin
					seg_stall = 1'b0;
					seg_left = 1;
				end
			end
			seg_left--;
			rsp_stall <= seg_stall && !no_gaps;
		end
	end

	always @(posedge clk) begin
		nvs_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (owed_answers.size() == 0) begin
				$error("result transaction with no query waiting: index %0d", rsp.result_index);
				mismatch_count++;
			end else begin
				want = owed_answers.pop_front();
				answers_checked++;
				if (rsp.result_index !== want.result_index) begin
					$error("result_index: expected %0d, actual %0d", want.result_index,
						rsp.result_index);
					mismatch_count++;
				end
				if (rsp.distance_sq !== want.distance_sq) begin
					$error("distance_sq: expected %0d, actual %0d", want.distance_sq,
						rsp.distance_sq);
					mismatch_count++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp.status);
					mismatch_count++;
				end
			end
		end
	end

	task automatic test_single_vertex();
		send_item(make_item(nvs_pkg::OP_LOAD, 0, -32768, -32768, -32768));
		send_item(make_item(nvs_pkg::OP_NEAREST, 0, 32767, 32767, 32767));
		send_item(make_item(nvs_pkg::OP_NEIGHBOR, 0, 5, -5, 5));
		send_item(make_item(nvs_pkg::OP_NEIGHBOR, 1, 0, 0, 0));
		send_item(make_item(OP_UNUSED, 1023, 32767, -32768, 32767));
	endtask

	task automatic test_tie_breaks();
		write_vertex_count(4);
		send_item(make_item(nvs_pkg::OP_LOAD, 1, 10, 0, 10));
		send_item(make_item(nvs_pkg::OP_LOAD, 2, 10, 0, 10));
		send_item(make_item(nvs_pkg::OP_LOAD, 3, 10, 5, 10));
		send_item(make_item(nvs_pkg::OP_NEAREST, 0, 10, 0, 10));
		send_item(make_item(nvs_pkg::OP_NEIGHBOR, 0, 10, 7, 10));
		send_item(make_item(nvs_pkg::OP_NEIGHBOR, 2, 10, 0, 10));
		send_item(make_item(nvs_pkg::OP_NEIGHBOR, 3, -32768, 0, -32768));
		send_item(make_item(nvs_pkg::OP_NEIGHBOR, 4, 0, 0, 0));
		send_item(make_item(nvs_pkg::OP_NEIGHBOR, 1023, 0, 0, 0));
	endtask

	task automatic test_count_extremes();
		write_vertex_count(0);
		send_item(make_item(nvs_pkg::OP_NEAREST, 0, 0, 0, 0));
		send_item(make_item(nvs_pkg::OP_NEIGHBOR, 1, 0, 0, 0));
		send_item(make_item(nvs_pkg::OP_NEIGHBOR, 0, 3, 3, 3));
		write_vertex_count(2);
		send_item(make_item(nvs_pkg::OP_NEIGHBOR, 1, 10, 0, 10));
		send_item(make_item(nvs_pkg::OP_NEIGHBOR, 0, -1, 0, -1));
	endtask

	task automatic test_random_small_counts();
		int r, count;
		for (int s = 0; s < 10; s++) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				count = $urandom_range(1, 8);
			else if (r < 90)
				count = $urandom_range(9, 40);
			else
				count = $urandom_range(41, 100);
			write_vertex_count(count);
			fill_table(active_nodes());
			no_gaps = (s % 4 == 3);
			random_burst(35, s % 3 == 1);
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_receiver_hold();
		no_gaps = 1'b1;
		hold_request = 1'b1;
		random_burst(12, 1'b0);
		no_gaps = 1'b0;
		wait_results_drained();
		random_burst(20, 1'b1);
	endtask

	task automatic test_full_table();
		fill_table(nvs_pkg::MAX_NODES);
		write_vertex_count(nvs_pkg::MAX_NODES);
		send_item(make_item(nvs_pkg::OP_NEAREST, 0, vertex_mem[nvs_pkg::MAX_NODES-1].x,
			vertex_mem[nvs_pkg::MAX_NODES-1].y, vertex_mem[nvs_pkg::MAX_NODES-1].z));
		send_item(make_item(nvs_pkg::OP_NEAREST, 0, random_coord(1'b0), random_coord(1'b0),
			random_coord(1'b0)));
		send_item(make_item(nvs_pkg::OP_NEIGHBOR, 0, 0, 0, 0));
		send_item(make_item(nvs_pkg::OP_NEIGHBOR, nvs_pkg::MAX_NODES - 1, -32768, 32767,
			32767));
		random_burst(8, 1'b0);
		write_vertex_count((1 << nvs_pkg::CNT_W) - 1);
		send_item(make_item(nvs_pkg::OP_NEAREST, 0, 32767, -32768, -32768));
		send_item(make_item(nvs_pkg::OP_NEIGHBOR, nvs_pkg::MAX_NODES - 1, 1, 1, 1));
		write_vertex_count(nvs_pkg::MAX_NODES - 1);
		send_item(make_item(nvs_pkg::OP_NEIGHBOR, nvs_pkg::MAX_NODES - 1, 0, 0, 0));
		send_item(make_item(nvs_pkg::OP_NEIGHBOR, 0, 0, 0, 0));
	endtask

	task automatic test_random_any_count();
		int r, count;
		for (int s = 0; s < 6; s++) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				count = $urandom_range(1, 16);
			else if (r < 80)
				count = $urandom_range(17, 256);
			else
				count = $urandom_range(257, (1 << nvs_pkg::CNT_W) - 1);
			write_vertex_count(count);
			no_gaps = (s == 2);
			random_burst(30, s % 2 == 1);
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_single_vertex();
		test_tie_breaks();
		test_count_extremes();
		test_random_small_counts();
		test_receiver_hold();
		test_full_table();
		test_random_any_count();
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Checked %0d query results, %0d of them out-of-range neighbor queries.",
			answers_checked, range_errors);
		$display("Sent %0d vertex loads over %0d vertex count settings, full table included.",
			loads_done, count_writes);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
